>>> rtl/core/rpcc_pkg.sv
package rpcc_pkg;

  localparam int COMP_W     = 16;
  localparam int SUM_W      = 18;
  localparam int DVS_W      = 18;
  localparam int PROD_W     = 34;
  localparam int REM_W      = 34;
  localparam int QUO_W      = 16;
  localparam int DOT_W      = 27;
  localparam int CH_W       = 17;
  localparam int SEP_PROD_W = 55;
  localparam int SEP_SHIFT  = 37;
  localparam int NUM_CELLS  = QUO_W;

  // ceil(2^37 / 1000), exact for every sepia dot product of 16-bit components
  localparam logic [27:0] SEP_RECIP = 28'd137438954;

  // sepia weights in thousandths, row per output channel, column per input channel
  localparam logic [9:0] SEP_COEF [3][3] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  typedef enum logic [2:0] {
    MODE_BINARIZE = 3'd0,
    MODE_GRAY     = 3'd1,
    MODE_ISOLATE  = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_SEPIA    = 3'd4
  } mode_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_CHAN_SEL  = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE = 2'd2;
  localparam logic [1:0] REG_GRAY_MAX  = 2'd3;

  typedef struct packed {
    logic [2:0]        mode;
    logic [1:0]        channel_sel;
    logic [COMP_W-1:0] max_value;
    logic [COMP_W-1:0] gray_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:        MODE_BINARIZE,
    channel_sel: CH_RED,
    max_value:   16'd255,
    gray_max:    16'd255
  };

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic                   vld;
    logic                   last;
    logic [2:0]             mode;
    logic                   bin_bit;
    logic [2:0][COMP_W-1:0] pass;
    logic [2:0][DOT_W-1:0]  dot;
    logic [PROD_W-1:0]      prod;
    logic [DVS_W-1:0]       dvs;
  } s1_t;

  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [2:0]           mode;
    logic                 bin_bit;
    logic [2:0][CH_W-1:0] ch;
    logic [REM_W-1:0]     rem;
    logic [REM_W-1:0]     dsh;
    logic [QUO_W-1:0]     quo;
    logic                 ovf;
  } cell_t;

endpackage

>>> rtl/core/rgb_pixel_color_converter_top.sv
// input passes stage 1, stage 2, the 16 grayscale divider cells and the output register
// throughput: one pixel per clock if not stalled, set by the 16-cell restoring divider chain
// in_tready comes from a one-deep input skid register, so input is decoupled from out_tready
// reset (rst_n low, synchronous) empties the pipeline and the skid stage and loads
// mode binarize, channel red, max_value 255 and gray_max 255
module rgb_pixel_color_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red_in, green_in, blue_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // red_out, green_out, blue_out, gray_out, bit_out
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import rpcc_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   skid_vld_r, skid_vld_nxt;
  pixel_t skid_r;
  pixel_t in_pix;
  pixel_t feed;
  logic   feed_vld;
  logic   in_xfer;
  logic   adv;
  cell_t  chain [NUM_CELLS+1];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:      cfg_nxt.mode        = cfg_wdata[2:0];
        REG_CHAN_SEL:  cfg_nxt.channel_sel = cfg_wdata[1:0];
        REG_MAX_VALUE: cfg_nxt.max_value   = cfg_wdata;
        REG_GRAY_MAX:  cfg_nxt.gray_max    = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // whole pipeline moves when the output register is free or being emptied
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = !skid_vld_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_pix.red   = in_tdata[15:0];
    in_pix.green = in_tdata[31:16];
    in_pix.blue  = in_tdata[47:32];
    in_pix.last  = in_tlast;

    feed     = skid_vld_r ? skid_r : in_pix;
    feed_vld = skid_vld_r || in_xfer;

    if (adv) begin
      skid_vld_nxt = 1'b0;
    end else begin
      skid_vld_nxt = skid_vld_r || in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // park a transfer that arrives while the pipeline is held
  always_ff @(posedge clk) begin
    if (!adv && in_xfer) begin
      skid_r <= in_pix;
    end
  end

  rpcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg_r),
    .feed_vld (feed_vld),
    .feed     (feed),
    .cell_o   (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rpcc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  rpcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .cell_i     (chain[NUM_CELLS]),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/rpcc_front.sv
module rpcc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  rpcc_pkg::cfg_t   cfg,
  input  logic             feed_vld,
  input  rpcc_pkg::pixel_t feed,
  output rpcc_pkg::cell_t  cell_o
);
  import rpcc_pkg::*;

  s1_t                        s1_r, s1_nxt;
  cell_t                      s2_r, s2_nxt;
  logic [2:0][COMP_W-1:0]     comp;
  logic [2:0]                 keep;
  logic [SUM_W-1:0]           sum;
  logic [16:0]                hm3;
  logic [2:0][SEP_PROD_W-1:0] sep_prod;

  // stage 1: sum, gray numerator, sepia dot products, threshold, channel masks
  always_comb begin
    comp = {feed.blue, feed.green, feed.red};
    sum  = SUM_W'(feed.red) + SUM_W'(feed.green) + SUM_W'(feed.blue);
    // floor(s/3) < floor(m/2) is the same as s < 3*floor(m/2)
    hm3  = {2'b00, cfg.max_value[COMP_W-1:1]} + {1'b0, cfg.max_value[COMP_W-1:1], 1'b0};

    keep = 3'b000;
    unique case (cfg.mode)
      MODE_ISOLATE: begin
        unique case (cfg.channel_sel)
          CH_RED:   keep = 3'b001;
          CH_GREEN: keep = 3'b010;
          CH_BLUE:  keep = 3'b100;
          default:  keep = 3'b111;
        endcase
      end
      MODE_REMOVE: begin
        unique case (cfg.channel_sel)
          CH_RED:   keep = 3'b110;
          CH_GREEN: keep = 3'b101;
          CH_BLUE:  keep = 3'b011;
          default:  keep = 3'b111;
        endcase
      end
      default: keep = 3'b000;
    endcase

    s1_nxt.vld     = feed_vld;
    s1_nxt.last    = feed.last;
    s1_nxt.mode    = cfg.mode;
    s1_nxt.bin_bit = (cfg.mode == MODE_BINARIZE) && !(sum < SUM_W'(hm3));
    for (int k = 0; k < 3; k++) begin
      s1_nxt.pass[k] = keep[k] ? comp[k] : '0;
      s1_nxt.dot[k]  = DOT_W'(feed.red)   * DOT_W'(SEP_COEF[k][0])
                     + DOT_W'(feed.green) * DOT_W'(SEP_COEF[k][1])
                     + DOT_W'(feed.blue)  * DOT_W'(SEP_COEF[k][2]);
    end
    s1_nxt.prod = PROD_W'(sum) * PROD_W'(cfg.gray_max);
    s1_nxt.dvs  = DVS_W'(cfg.max_value) + DVS_W'({cfg.max_value, 1'b0});
  end

  // stage 2: divide sepia sums by 1000, set up the restoring divider
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sep_prod[k] = SEP_PROD_W'(s1_r.dot[k]) * SEP_PROD_W'(SEP_RECIP);
    end

    s2_nxt.vld     = s1_r.vld;
    s2_nxt.last    = s1_r.last;
    s2_nxt.mode    = s1_r.mode;
    s2_nxt.bin_bit = s1_r.bin_bit;
    for (int k = 0; k < 3; k++) begin
      s2_nxt.ch[k] = (s1_r.mode == MODE_SEPIA) ? sep_prod[k][SEP_SHIFT +: CH_W]
                                                : CH_W'(s1_r.pass[k]);
    end
    s2_nxt.rem = s1_r.prod;
    s2_nxt.dsh = REM_W'({s1_r.dvs, {(QUO_W-1){1'b0}}});
    s2_nxt.quo = '0;
    // quotient does not fit in 16 bits, so it saturates anyway (also zero divisor)
    s2_nxt.ovf = s1_r.prod >= REM_W'({s1_r.dvs, {QUO_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign cell_o = s2_r;

endmodule

>>> rtl/core/rpcc_div_cell.sv
module rpcc_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  rpcc_pkg::cell_t cell_i,
  output rpcc_pkg::cell_t cell_o
);
  import rpcc_pkg::*;

  cell_t cell_r, cell_nxt;
  logic  ge;

  // one restoring step: try the shifted divisor, keep one quotient bit
  always_comb begin
    cell_nxt = cell_i;
    ge       = cell_i.rem >= cell_i.dsh;
    if (ge) begin
      cell_nxt.rem = cell_i.rem - cell_i.dsh;
    end
    cell_nxt.quo = {cell_i.quo[QUO_W-2:0], ge};
    cell_nxt.dsh = cell_i.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

>>> rtl/core/rpcc_back.sv
module rpcc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  rpcc_pkg::cfg_t  cfg,
  input  rpcc_pkg::cell_t cell_i,
  output logic            out_tvalid,
  output logic [71:0]     out_tdata,
  output logic            out_tlast
);
  import rpcc_pkg::*;

  logic                   out_vld_r;
  logic [71:0]            out_data_r, out_data_nxt;
  logic                   out_last_r;
  logic [2:0][COMP_W-1:0] rgb;
  logic [COMP_W-1:0]      gray;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ((cell_i.mode == MODE_SEPIA) && (cell_i.ch[k] > CH_W'(cfg.max_value))) begin
        rgb[k] = cfg.max_value;
      end else begin
        rgb[k] = cell_i.ch[k][COMP_W-1:0];
      end
    end

    gray = '0;
    if (cell_i.mode == MODE_GRAY) begin
      if (cell_i.ovf || (cell_i.quo > cfg.gray_max)) begin
        gray = cfg.gray_max;
      end else begin
        gray = cell_i.quo;
      end
    end

    out_data_nxt = {7'b0000000, cell_i.bin_bit, gray, rgb[2], rgb[1], rgb[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_last_r <= cell_i.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sim/tb_rgb_pixel_color_converter_top.sv
module tb_rgb_pixel_color_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpcc_pkg::*;

  // mode and channel codes that the block must treat as out of range
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [1:0] CH_NONE        = 2'd3;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RAND_PHASES = 35;
  localparam int unsigned PHASE_PIXELS = 50;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] gray;
    logic        mono;
    logic        last;
  } px_res_t;

  class conv_tracker;
    px_res_t     pending[$];
    cfg_t        cfg;
    int unsigned errors;
    int unsigned n_pix;
    int unsigned n_res;
    int unsigned n_settings;
    int unsigned n_mode[8];

    function new();
      cfg = CFG_RESET;
      errors = 0;
      n_pix = 0;
      n_res = 0;
      n_settings = 1;
      foreach (n_mode[i]) n_mode[i] = 0;
    endfunction

    function logic [15:0] sepia_dot(longint unsigned r, longint unsigned g, longint unsigned b,
                                    longint unsigned kr, longint unsigned kg,
                                    longint unsigned kb, longint unsigned mv);
      longint unsigned v;
      v = (kr * r + kg * g + kb * b) / 1000;
      if (v > mv) v = mv;
      return v[15:0];
    endfunction

    function px_res_t convert_pixel(pixel_t p);
      px_res_t res;
      longint unsigned r, g, b, sum, mv, gm, q;
      r = p.red;
      g = p.green;
      b = p.blue;
      sum = r + g + b;
      mv = cfg.max_value;
      gm = cfg.gray_max;
      res = '0;
      res.last = p.last;
      case (cfg.mode)
        MODE_BINARIZE: res.mono = (sum / 3 < mv / 2) ? 1'b0 : 1'b1;
        MODE_GRAY: begin
          // zero max_value skips the division and gives full gray
          if (mv == 0) begin
            q = gm;
          end else begin
            q = (sum * gm) / (3 * mv);
            if (q > gm) q = gm;
          end
          res.gray = q[15:0];
        end
        MODE_ISOLATE: begin
          res.red = p.red;
          res.green = p.green;
          res.blue = p.blue;
          case (cfg.channel_sel)
            CH_RED: begin
              res.green = '0;
              res.blue = '0;
            end
            CH_GREEN: begin
              res.red = '0;
              res.blue = '0;
            end
            CH_BLUE: begin
              res.red = '0;
              res.green = '0;
            end
            default: ;
          endcase
        end
        MODE_REMOVE: begin
          res.red = p.red;
          res.green = p.green;
          res.blue = p.blue;
          case (cfg.channel_sel)
            CH_RED:   res.red = '0;
            CH_GREEN: res.green = '0;
            CH_BLUE:  res.blue = '0;
            default: ;
          endcase
        end
        MODE_SEPIA: begin
          // all three rows use the untouched input components
          res.red = sepia_dot(r, g, b, 393, 769, 189, mv);
          res.green = sepia_dot(r, g, b, 349, 686, 168, mv);
          res.blue = sepia_dot(r, g, b, 272, 534, 131, mv);
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      pending.push_back(convert_pixel(p));
      n_pix++;
      n_mode[cfg.mode]++;
    endfunction

    function void field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(px_res_t got);
      px_res_t want;
      if (pending.size() == 0) begin
        $error("output transfer with no pixel outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      n_res++;
      field_ok("red_out", want.red, got.red);
      field_ok("green_out", want.green, got.green);
      field_ok("blue_out", want.blue, got.blue);
      field_ok("gray_out", want.gray, got.gray);
      field_ok("bit_out", want.mono, got.mono);
      field_ok("last_out", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  conv_tracker sb = new();
  logic        steady = 1'b0;
  int unsigned quiet = 0;

  rgb_pixel_color_converter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd255;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(1, 1023));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // mostly within the image range so thresholds and clamps are hit from both sides
  function automatic logic [15:0] pick_comp(logic [15:0] mv);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return mv;
      3, 4, 5, 6: return 16'($urandom_range(0, mv));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic lst);
    int unsigned gap;
    pixel_t p;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    p = '{red: r, green: g, blue: b, last: lst};
    sb.note_pixel(p);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MODE:      sb.cfg.mode = val[2:0];
      REG_CHAN_SEL:  sb.cfg.channel_sel = val[1:0];
      REG_MAX_VALUE: sb.cfg.max_value = val;
      REG_GRAY_MAX:  sb.cfg.gray_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // unused upper bits of the narrow registers carry junk that must be ignored
  task automatic set_cfg(input logic [2:0] m, input logic [1:0] ch, input logic [15:0] mv,
                         input logic [15:0] gm);
    drain();
    write_reg(REG_MODE, (16'($urandom) & 16'hFFF8) | 16'(m));
    write_reg(REG_CHAN_SEL, (16'($urandom) & 16'hFFFC) | 16'(ch));
    write_reg(REG_MAX_VALUE, mv);
    write_reg(REG_GRAY_MAX, gm);
    sb.n_settings++;
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      int unsigned burst, stall;
      @(negedge clk);
      out_tready <= 1'b1;
      burst = steady ? 64 : $urandom_range(1, 16);
      repeat (burst - 1) @(negedge clk);
      stall = steady ? 0 : pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pixel('{red: out_tdata[15:0], green: out_tdata[31:16],
                       blue: out_tdata[47:32], gray: out_tdata[63:48],
                       mono: out_tdata[64], last: out_tlast});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0]  m;
    logic [15:0] mv;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: binarize against 255, threshold edges around 127
    send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'd127, 16'd127, 16'd127, 1'b0);
    send_pixel(16'd126, 16'd127, 16'd127, 1'b0);

    set_cfg(MODE_GRAY, CH_RED, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'd1, 16'd0, 16'd0, 1'b0);
    set_cfg(MODE_GRAY, CH_GREEN, 16'd1, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 1'b0);

    // zero max_value in the three modes that use it
    set_cfg(MODE_GRAY, CH_BLUE, 16'd0, 16'd1234);
    send_pixel(16'd5, 16'd6, 16'd7, 1'b0);
    set_cfg(MODE_BINARIZE, CH_RED, 16'd0, 16'd255);
    send_pixel(16'd0, 16'd0, 16'd0, 1'b1);
    set_cfg(MODE_SEPIA, CH_RED, 16'd0, 16'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    set_cfg(MODE_ISOLATE, CH_RED, 16'd255, 16'd255);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    set_cfg(MODE_ISOLATE, CH_GREEN, 16'd255, 16'd255);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1);
    set_cfg(MODE_ISOLATE, CH_BLUE, 16'd255, 16'd255);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    set_cfg(MODE_ISOLATE, CH_NONE, 16'd255, 16'd255);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    set_cfg(MODE_REMOVE, CH_RED, 16'd255, 16'd255);
    send_pixel(16'hEDCB, 16'hA987, 16'h6543, 1'b0);
    set_cfg(MODE_REMOVE, CH_GREEN, 16'd255, 16'd255);
    send_pixel(16'hEDCB, 16'hA987, 16'h6543, 1'b1);
    set_cfg(MODE_REMOVE, CH_BLUE, 16'd255, 16'd255);
    send_pixel(16'hEDCB, 16'hA987, 16'h6543, 1'b0);
    set_cfg(MODE_REMOVE, CH_NONE, 16'd255, 16'd255);
    send_pixel(16'hEDCB, 16'hA987, 16'h6543, 1'b0);

    set_cfg(MODE_SEPIA, CH_RED, 16'hFFFF, 16'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'd1000, 16'd2000, 16'd3000, 1'b0);

    set_cfg(MODE_UNUSED_LO, CH_GREEN, 16'd255, 16'd255);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    set_cfg(MODE_UNUSED_HI, CH_BLUE, 16'd255, 16'd255);
    send_pixel(16'hFFFF, 16'h0001, 16'h8000, 1'b0);

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      m = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(MODE_BINARIZE, MODE_SEPIA))
                                     : 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      mv = pick_level();
      set_cfg(m, 2'($urandom_range(CH_RED, CH_NONE)), mv, pick_level());
      steady = ($urandom_range(0, 5) == 0);
      for (int unsigned i = 0; i < PHASE_PIXELS; i++) begin
        send_pixel(pick_comp(mv), pick_comp(mv), pick_comp(mv), $urandom_range(0, 7) == 0);
      end
    end

    steady = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    $display("converted %0d pixels, %0d results checked, over %0d register settings",
             sb.n_pix, sb.n_res, sb.n_settings);
    $display("pixels per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.n_mode[0], sb.n_mode[1], sb.n_mode[2], sb.n_mode[3],
             sb.n_mode[4], sb.n_mode[5], sb.n_mode[6], sb.n_mode[7]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
